FILE: design/hdrt_pkg.sv
// Package: shared types, constants and the half-to-R11G11B10 channel packer.
package hdrt_pkg;

	localparam int HALF_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int PACK_W   = 32;
	localparam int MODE_W   = 2;
	// tonemap fixed point: V = v * 2^24 fits 40 bits, numerator 49, shifted divisor 48
	localparam int TM_VW    = 40;
	localparam int TM_DW    = 42;
	localparam int TM_NW    = 50;
	localparam int TM_QW    = 8;
	localparam int LANE_STG = 2 + TM_QW;

	localparam logic [TM_VW-1:0] TM_ONE = TM_VW'(1) << 24;

	localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PACK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TONE = 2'd2;

	localparam logic [4:0] HALF_EXP_ALL = 5'h1F;
	localparam logic [5:0] PACK_MAX_EXP = 6'h1E;

	typedef struct packed {
		logic [HALF_W-1:0] red;
		logic [HALF_W-1:0] green;
		logic [HALF_W-1:0] blue;
		logic [HALF_W-1:0] alpha;
	} pix_t;

	typedef struct packed {
		logic [PACK_W-1:0] packed_w;
		logic [HALF_W-1:0] red;
		logic [HALF_W-1:0] green;
		logic [HALF_W-1:0] blue;
		logic [HALF_W-1:0] alpha;
	} res_t;

	// Half to unsigned small float: 6-bit mantissa (blue = 0) or 5-bit (blue = 1).
	// Result is right aligned: 11 bits for red/green, 10 bits for blue.
	function automatic logic [10:0] pack_chan(input logic [HALF_W-1:0] h, input logic blue);
		logic [4:0]  e;
		logic [9:0]  m;
		logic [10:0] sum;
		logic        carry;
		logic [5:0]  mant;
		logic [5:0]  ex;
		logic [10:0] res;
		e = h[14:10];
		m = h[9:0];
		if (blue) begin
			sum   = {1'b0, m} + 11'd16;
			carry = sum[10];
			mant  = {1'b0, sum[9:5]};
		end else begin
			sum   = {1'b0, m} + 11'd8;
			carry = sum[10];
			mant  = sum[9:4];
		end
		if (carry) begin
			mant = 6'd0;
		end
		ex = {1'b0, e} + {5'd0, carry};
		if (ex > PACK_MAX_EXP) begin
			ex   = PACK_MAX_EXP;
			mant = blue ? 6'h1F : 6'h3F;
		end
		res = blue ? {1'b0, ex[4:0], mant[4:0]} : {ex[4:0], mant};
		if (h[15] || (e == HALF_EXP_ALL && m != 10'd0) || (e == 5'd0 && m == 10'd0)) begin
			res = 11'd0;
		end
		return res;
	endfunction

endpackage

FILE: design/hdrt_in_if.sv
// Interface: input pixel channel, four half-float channels per beat.
interface hdrt_in_if;
	import hdrt_pkg::*;

	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] in_red;
	logic [HALF_W-1:0] in_green;
	logic [HALF_W-1:0] in_blue;
	logic [HALF_W-1:0] in_alpha;

	modport source (output valid, output in_red, output in_green, output in_blue,
		output in_alpha, input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		input in_alpha, output ready);
endinterface

FILE: design/hdrt_out_if.sv
// Interface: output result channel, packed word plus four 16-bit channels per beat.
interface hdrt_out_if;
	import hdrt_pkg::*;

	logic              valid;
	logic              ready;
	logic [PACK_W-1:0] out_packed;
	logic [HALF_W-1:0] out_red;
	logic [HALF_W-1:0] out_green;
	logic [HALF_W-1:0] out_blue;
	logic [HALF_W-1:0] out_alpha;

	modport source (output valid, output out_packed, output out_red, output out_green,
		output out_blue, output out_alpha, input ready);
	modport sink (input valid, input out_packed, input out_red, input out_green,
		input out_blue, input out_alpha, output ready);
endinterface

FILE: design/hdrt_tone_lane.sv
// Module: one tonemap lane, half to Reinhard byte via a pipelined restoring divider.
module hdrt_tone_lane (
	input  logic                           clk,
	input  logic [hdrt_pkg::LANE_STG-1:0]  en,
	input  logic [hdrt_pkg::HALF_W-1:0]    h,
	output logic [hdrt_pkg::BYTE_W-1:0]    tone
);
	import hdrt_pkg::*;

	logic [4:0]       e;
	logic [9:0]       m;
	logic [TM_VW-1:0] v_d;
	logic             sat_d;

	logic [TM_VW-1:0] v_s1;
	logic             sat_s1;
	logic [TM_NW-1:0] n_s2;
	logic [TM_DW-1:0] d_s2;
	logic             sat_s2;

	// divider stages, one quotient bit each, msb first
	logic [TM_NW-1:0] rem_s [TM_QW];
	logic [TM_DW-1:0] den_s [TM_QW];
	logic [TM_QW-1:0] quo_s [TM_QW];
	logic             sat_s [TM_QW];

	// decode: negative and NaN map to V = 0, infinity flagged as saturate
	always_comb begin
		e     = h[14:10];
		m     = h[9:0];
		v_d   = '0;
		sat_d = 1'b0;
		if (h[15]) begin
			v_d = '0;
		end else if (e == HALF_EXP_ALL) begin
			sat_d = (m == 10'd0);
		end else if (e == 5'd0) begin
			v_d = {30'd0, m};
		end else begin
			v_d = {29'd0, 1'b1, m} << (e - 5'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s1   <= v_d;
			sat_s1 <= sat_d;
		end
		// N = 511*V + 2^24, D = 2*(2^24 + V)
		if (en[1]) begin
			n_s2   <= ({10'd0, v_s1} << 9) - {10'd0, v_s1} + {10'd0, TM_ONE};
			d_s2   <= ({2'd0, v_s1} + {2'd0, TM_ONE}) << 1;
			sat_s2 <= sat_s1;
		end
	end

	for (genvar j = 0; j < TM_QW; j++) begin : g_div
		logic [TM_NW-1:0] rem_i;
		logic [TM_DW-1:0] den_i;
		logic [TM_QW-1:0] quo_i;
		logic             sat_i;
		logic [TM_NW-1:0] dsh;
		logic             ge;

		if (j == 0) begin : g_first
			assign rem_i = n_s2;
			assign den_i = d_s2;
			assign quo_i = '0;
			assign sat_i = sat_s2;
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign den_i = den_s[j-1];
			assign quo_i = quo_s[j-1];
			assign sat_i = sat_s[j-1];
		end

		assign dsh = {{(TM_NW-TM_DW){1'b0}}, den_i} << (TM_QW - 1 - j);
		assign ge  = (rem_i >= dsh);

		always_ff @(posedge clk) begin
			if (en[2+j]) begin
				rem_s[j] <= ge ? (rem_i - dsh) : rem_i;
				den_s[j] <= den_i;
				quo_s[j] <= {quo_i[TM_QW-2:0], ge};
				sat_s[j] <= sat_i;
			end
		end
	end

	assign tone = sat_s[TM_QW-1] ? {BYTE_W{1'b1}} : quo_s[TM_QW-1];
endmodule

FILE: design/hdrt_merge.sv
// Module: merge stage, packs RGB and selects the result fields by output mode.
module hdrt_merge (
	input  logic [hdrt_pkg::MODE_W-1:0] mode,
	input  hdrt_pkg::pix_t              pix,
	input  logic [hdrt_pkg::BYTE_W-1:0] tone_r,
	input  logic [hdrt_pkg::BYTE_W-1:0] tone_g,
	input  logic [hdrt_pkg::BYTE_W-1:0] tone_b,
	output hdrt_pkg::res_t              res
);
	import hdrt_pkg::*;

	logic [10:0] pk_r;
	logic [10:0] pk_g;
	logic [10:0] pk_b;

	assign pk_r = pack_chan(pix.red, 1'b0);
	assign pk_g = pack_chan(pix.green, 1'b0);
	assign pk_b = pack_chan(pix.blue, 1'b1);

	always_comb begin
		res = '0;
		unique case (mode)
			MODE_PASS: begin
				res.red   = pix.red;
				res.green = pix.green;
				res.blue  = pix.blue;
				res.alpha = pix.alpha;
			end
			MODE_PACK: begin
				res.packed_w = {pk_b[9:0], pk_g, pk_r};
			end
			MODE_TONE: begin
				res.red   = {8'd0, tone_r};
				res.green = {8'd0, tone_g};
				res.blue  = {8'd0, tone_b};
				res.alpha = 16'd255;
			end
			default: begin
				res = '0;
			end
		endcase
	end
endmodule

FILE: design/hdr_pixel_format_transcoder.sv
// Top level: HDR pixel transcoder, passthrough / R11G11B10 pack / Reinhard RGBA8.
// One pixel (four half-float channels) per beat in, one result beat out per pixel.
// Throughput is one pixel per clock while pix_out is not stalling. An accepted pixel
// runs through the stages of the tonemap lanes: a decode stage, an operand stage
// (N = 511V + 2^24, D = 2(2^24 + V)) and an eight-stage restoring divider, one quotient
// bit per stage, followed by the output register. The pipeline collapses bubbles, so
// a new pixel is taken while a finished result waits, until every stage is full.
// output_mode is written through cfg_we/cfg_wdata and must only change while idle.
// Mode 3 returns all-zero results.
module hdr_pixel_format_transcoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hdrt_pkg::MODE_W-1:0] cfg_wdata,
	hdrt_in_if.sink                     pix_in,
	hdrt_out_if.source                  pix_out
);
	import hdrt_pkg::*;

	logic [MODE_W-1:0]   mode_q;
	logic [LANE_STG-1:0] vld_q;
	logic [LANE_STG-1:0] rdy;
	pix_t                pix_q [LANE_STG];
	pix_t                pix_d;
	logic                out_vld_q;
	logic                out_rdy;
	res_t                res;
	res_t                res_q;
	logic [BYTE_W-1:0]   tone_r;
	logic [BYTE_W-1:0]   tone_g;
	logic [BYTE_W-1:0]   tone_b;
	logic                in_acc;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PASS;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// per-stage ready: a stage loads when it is empty or its successor moves
	assign out_rdy = !out_vld_q || pix_out.ready;
	always_comb begin
		rdy[LANE_STG-1] = !vld_q[LANE_STG-1] || out_rdy;
		for (int k = LANE_STG - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign pix_in.ready = rdy[0];
	assign in_acc       = pix_in.valid && rdy[0];

	assign pix_d.red   = pix_in.in_red;
	assign pix_d.green = pix_in.in_green;
	assign pix_d.blue  = pix_in.in_blue;
	assign pix_d.alpha = pix_in.in_alpha;

	// valid bits ride alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= pix_in.valid;
			end
			for (int k = 1; k < LANE_STG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (out_rdy) begin
				out_vld_q <= vld_q[LANE_STG-1];
			end
		end
	end

	// raw pixel delay line, used by passthrough and pack at the merge stage
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			pix_q[0] <= pix_d;
		end
		for (int k = 1; k < LANE_STG; k++) begin
			if (rdy[k]) begin
				pix_q[k] <= pix_q[k-1];
			end
		end
		if (out_rdy) begin
			res_q <= res;
		end
	end

	// three tonemap lanes, one per color channel
	hdrt_tone_lane u_lane_r (.clk(clk), .en(rdy), .h(pix_d.red),   .tone(tone_r));
	hdrt_tone_lane u_lane_g (.clk(clk), .en(rdy), .h(pix_d.green), .tone(tone_g));
	hdrt_tone_lane u_lane_b (.clk(clk), .en(rdy), .h(pix_d.blue),  .tone(tone_b));

	hdrt_merge u_merge (
		.mode   (mode_q),
		.pix    (pix_q[LANE_STG-1]),
		.tone_r (tone_r),
		.tone_g (tone_g),
		.tone_b (tone_b),
		.res    (res)
	);

	assign pix_out.valid      = out_vld_q;
	assign pix_out.out_packed = res_q.packed_w;
	assign pix_out.out_red    = res_q.red;
	assign pix_out.out_green  = res_q.green;
	assign pix_out.out_blue   = res_q.blue;
	assign pix_out.out_alpha  = res_q.alpha;

	// a stalled result beat stays in the output register
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !pix_out.ready |=> out_vld_q)
		else $error("output beat lost while stalled");

	// first stage empties when it is free and nothing is taken
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rdy[0] && !in_acc |=> !vld_q[0])
		else $error("first stage valid without an accepted beat");

	// pack mode leaves the channel fields at zero
	a_pack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && mode_q == MODE_PACK |-> res_q.red == '0 && res_q.alpha == '0)
		else $error("channel fields nonzero in pack mode");

	// tonemap results are bytes with opaque alpha
	a_tone_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && mode_q == MODE_TONE |->
		res_q.red[15:8] == 8'd0 && res_q.blue[15:8] == 8'd0 && res_q.alpha == 16'd255)
		else $error("tonemap result out of byte range");
endmodule

FILE: tb/sv/hdr_pixel_format_transcoder_tb.sv
// Testbench: hdr_pixel_format_transcoder, self-checking, predicted results, random handshake timing.
module hdr_pixel_format_transcoder_tb;
	import hdrt_pkg::*;

	// mode 3 has no use; the block answers it with all-zero beats
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	localparam int unsigned RG_MANT  = 6;    // red/green mantissa bits in the packed word
	localparam int unsigned B_MANT   = 5;    // blue mantissa bits
	localparam int unsigned G_SHIFT  = 11;
	localparam int unsigned B_SHIFT  = 22;
	localparam longint unsigned TONE_ONE = 64'd1 << 24;   // 1.0 in the tonemap fixed point
	localparam logic [HALF_W-1:0] TONE_ALPHA = 16'd255;
	localparam int unsigned BYTE_MAX = 255;

	localparam int DRAIN_CYCLES = 16;   // pipeline is 11 deep, plus margin
	localparam int HOLD_CYCLES  = 60;   // long receiver hold-off, several times the depth

	// Scoreboard: predicts each pixel at the beat it is accepted, checks beats in order.
	class transcode_scoreboard;
		res_t               expected_pixels[$];
		logic [MODE_W-1:0]  mode;
		int                 errors;
		int                 per_mode[4];

		function new();
			mode   = MODE_PASS;
			errors = 0;
			foreach (per_mode[k]) per_mode[k] = 0;
		endfunction

		function void set_mode(logic [MODE_W-1:0] m);
			mode = m;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		// half to unsigned small float, right aligned
		function logic [10:0] pack_half(logic [HALF_W-1:0] h, int unsigned mbits);
			int unsigned e;
			int unsigned m;
			int unsigned sh;
			e  = h[14:10];
			m  = h[9:0];
			sh = 10 - mbits;
			// negatives, both zeros and NaN collapse to 0
			if (h[15])
				return '0;
			if (e == HALF_EXP_ALL && m != 0)
				return '0;
			if (e == 0 && m == 0)
				return '0;
			m = (m + (1 << (sh - 1))) >> sh;
			// rounding carry moves into the exponent
			if (m >= (1 << mbits)) begin
				m = 0;
				e++;
			end
			// overflow and infinity saturate to the largest finite code
			if (e > PACK_MAX_EXP) begin
				e = PACK_MAX_EXP;
				m = (1 << mbits) - 1;
			end
			return 11'((e << mbits) | m);
		endfunction

		// Reinhard v/(1+v) scaled to a byte, exact: V = v * 2^24
		function logic [BYTE_W-1:0] tonemap_half(logic [HALF_W-1:0] h);
			int unsigned     e;
			int unsigned     m;
			longint unsigned v;
			longint unsigned num;
			longint unsigned den;
			longint unsigned q;
			e = h[14:10];
			m = h[9:0];
			if (h[15])
				return '0;
			if (e == HALF_EXP_ALL)
				return (m != 0) ? 8'd0 : 8'd255;
			if (e == 0) begin
				v = 64'(m);
			end else begin
				v = 64'(1024 + m);
				v = v << (e - 1);
			end
			num = 510 * v + TONE_ONE + v;
			den = 2 * (TONE_ONE + v);
			q   = num / den;
			return (q > BYTE_MAX) ? 8'd255 : 8'(q);
		endfunction

		function res_t transcode_pixel(pix_t p);
			res_t r;
			r = '0;
			case (mode)
				MODE_PASS: begin
					r.red   = p.red;
					r.green = p.green;
					r.blue  = p.blue;
					r.alpha = p.alpha;
				end
				MODE_PACK: begin
					r.packed_w = 32'(pack_half(p.red, RG_MANT))
						| (32'(pack_half(p.green, RG_MANT)) << G_SHIFT)
						| (32'(pack_half(p.blue, B_MANT)) << B_SHIFT);
				end
				MODE_TONE: begin
					r.red   = 16'(tonemap_half(p.red));
					r.green = 16'(tonemap_half(p.green));
					r.blue  = 16'(tonemap_half(p.blue));
					r.alpha = TONE_ALPHA;
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_pixel(pix_t p);
			expected_pixels.push_back(transcode_pixel(p));
			per_mode[mode]++;
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_pixels.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, actual %h", $time, got);
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("out_packed", want.packed_w, got.packed_w);
			compare_field("out_red", 32'(want.red), 32'(got.red));
			compare_field("out_green", 32'(want.green), 32'(got.green));
			compare_field("out_blue", 32'(want.blue), 32'(got.blue));
			compare_field("out_alpha", 32'(want.alpha), 32'(got.alpha));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;

	hdrt_in_if  pix_in();
	hdrt_out_if pix_out();

	hdr_pixel_format_transcoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	transcode_scoreboard sb = new();

	// handshake pacing, written only by the stimulus process
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	// owned by the receiver process
	int hold_done = 0;
	int hold_left = 0;
	int stalled_offers = 0;

	// edge cases every channel should see in the directed part
	logic [HALF_W-1:0] edge_halves[14] = '{
		16'h0000,   // +0
		16'h8000,   // -0
		16'h0001,   // smallest subnormal
		16'h03FF,   // largest subnormal, rounds up to the normal range
		16'h0008,   // red/green half-way tie
		16'h0010,   // blue half-way tie
		16'h3C00,   // 1.0
		16'h3BFF,   // mantissa all ones, rounding carries into the exponent
		16'h7BFF,   // largest finite, carry pushes past exponent 30
		16'h7BF8,   // largest finite with a partial tail
		16'h7C00,   // +inf
		16'h7E00,   // NaN
		16'hFC00,   // -inf
		16'hBC00    // -1.0
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: checks each accepted result beat, then picks ready for the next edge.
	// A hold-off request from the stimulus side pulls ready low for HOLD_CYCLES.
	always @(posedge clk) begin
		res_t beat;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			beat = '{packed_w: pix_out.out_packed, red: pix_out.out_red,
				green: pix_out.out_green, blue: pix_out.out_blue, alpha: pix_out.out_alpha};
			sb.check_result(beat);
		end
		if (hold_left > 0) begin
			hold_left--;
			pix_out.ready <= 1'b0;
		end else if (hold_reqs != hold_done) begin
			hold_done++;
			hold_left = HOLD_CYCLES - 1;
			pix_out.ready <= 1'b0;
		end else begin
			pix_out.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one pixel until it is taken, then maybe idle the input for a while.
	// valid stays high into the next call when there is no gap.
	task automatic send_pixel(input pix_t p);
		int gap;
		pix_in.valid    <= 1'b1;
		pix_in.in_red   <= p.red;
		pix_in.in_green <= p.green;
		pix_in.in_blue  <= p.blue;
		pix_in.in_alpha <= p.alpha;
		do begin
			@(posedge clk);
			if (!pix_in.ready)
				stalled_offers++;
		end while (!pix_in.ready);
		sb.note_pixel(p);
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every expected beat, then let the pipe settle.
	task automatic wait_drain();
		pix_in.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic set_mode(input logic [MODE_W-1:0] m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_mode(m);
	endtask

	// Random half: plain random bits plus weight on the interesting regions.
	function automatic logic [HALF_W-1:0] rand_half();
		logic [4:0] ex;
		case ($urandom_range(9))
			0, 1, 2, 3: return 16'($urandom);
			4: return {1'b0, 5'd0, 10'($urandom)};
			5: begin
				case ($urandom_range(3))
					0: ex = 5'd0;
					1: ex = 5'd1;
					2: ex = 5'd30;
					default: ex = 5'd31;
				endcase
				return {1'($urandom_range(3) == 0), ex, 10'($urandom)};
			end
			6: return {1'b0, 5'($urandom), 7'h7F, 3'($urandom)};   // near a rounding carry
			7: return {1'b0, 5'($urandom), 5'($urandom), 1'($urandom), 4'h0};  // blue half-way ties
			default: return {1'b0, 5'($urandom_range(8, 22)), 10'($urandom)};  // around 1.0
		endcase
	endfunction

	task automatic run_directed(input logic [MODE_W-1:0] m, input int n);
		pix_t p;
		set_mode(m);
		for (int i = 0; i < n; i++) begin
			p = '{red: edge_halves[(3 * i) % 14], green: edge_halves[(3 * i + 1) % 14],
				blue: edge_halves[(3 * i + 2) % 14], alpha: edge_halves[(3 * i + 3) % 14]};
			send_pixel(p);
		end
		wait_drain();
	endtask

	task automatic run_phase(input logic [MODE_W-1:0] m, input int s_idle, input int r_stall,
			input int n, input bit long_hold, input bit mid_drain);
		pix_t p;
		wait_drain();
		set_mode(m);
		idle_pct  = s_idle;
		stall_pct = r_stall;
		// the receiver freezes while the sender keeps offering: the pipe fills, input stalls
		if (long_hold)
			hold_reqs++;
		for (int i = 0; i < n; i++) begin
			// sender stops until every beat in flight has come back
			if (mid_drain && i == n / 2)
				wait_drain();
			p = '{red: rand_half(), green: rand_half(), blue: rand_half(), alpha: rand_half()};
			send_pixel(p);
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = MODE_PASS;
		pix_in.valid    = 1'b0;
		pix_in.in_red   = '0;
		pix_in.in_green = '0;
		pix_in.in_blue  = '0;
		pix_in.in_alpha = '0;
		pix_out.ready   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all edge halves through pack and tonemap, a few through the rest
		run_directed(MODE_PACK, 8);
		run_directed(MODE_TONE, 8);
		run_directed(MODE_PASS, 3);
		run_directed(MODE_NONE, 2);

		//        mode       idle stall  items hold pause
		run_phase(MODE_PACK, 0,   0,     160,  1'b0, 1'b0);
		run_phase(MODE_TONE, 55,  0,     160,  1'b0, 1'b0);
		run_phase(MODE_PACK, 0,   55,    160,  1'b0, 1'b0);
		run_phase(MODE_TONE, 21,  21,    160,  1'b0, 1'b1);
		run_phase(MODE_PASS, 21,  21,    100,  1'b0, 1'b0);
		run_phase(MODE_TONE, 0,   0,     160,  1'b1, 1'b0);
		run_phase(MODE_PACK, 21,  21,    140,  1'b1, 1'b0);
		run_phase(MODE_NONE, 0,   55,    40,   1'b0, 1'b0);
		wait_drain();

		$display("Covered %0d passthrough, %0d packed, %0d tonemapped, %0d unused-mode pixels.",
			sb.per_mode[MODE_PASS], sb.per_mode[MODE_PACK], sb.per_mode[MODE_TONE],
			sb.per_mode[MODE_NONE]);
		$display("Receiver held off %0d times; input back-pressured on %0d offered cycles.",
			hold_done, stalled_offers);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d beats outstanding", sb.errors, sb.pending());
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("%0t: timeout, %0d beats outstanding", $time, sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: hdr_pixel_format_transcoder.f
design/hdrt_pkg.sv
design/hdrt_in_if.sv
design/hdrt_out_if.sv
design/hdrt_tone_lane.sv
design/hdrt_merge.sv
design/hdr_pixel_format_transcoder.sv
tb/sv/hdr_pixel_format_transcoder_tb.sv
